// ----- hw/rtl/band_clip_and_stretch_macros.svh -----
// Assertion macros shared by the band clip and stretch RTL.
`ifndef BAND_CLIP_AND_STRETCH_MACROS_SVH
`define BAND_CLIP_AND_STRETCH_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define BCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcs assertion failed");
// Checked property that also holds during reset.
`define BCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bcs assertion failed");
`else
`define BCS_ASSERT(label, clk, rst_n, prop)
`define BCS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/bcs_pkg.sv -----
// Package: shared types, codes and defaults of the band clip and stretch block.
package bcs_pkg;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 64;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 2;

    localparam int DEF_BANDS         = 4;
    localparam int DEF_FRAC_BITS     = 15;
    localparam int DEF_NORM_MIN_CODE = 1;
    localparam int DEF_NORM_MAX_CODE = 32768;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_CLIP   = 3'd1;
    localparam logic [2:0] MODE_CLAMP  = 3'd2;
    localparam logic [2:0] MODE_LINEAR = 3'd3;
    localparam logic [2:0] MODE_MEDIAN = 3'd4;

    localparam logic [2:0] REG_CLIP_MODE = 3'd0;
    localparam logic [2:0] REG_LOW       = 3'd1;
    localparam logic [2:0] REG_HIGH      = 3'd2;
    localparam logic [2:0] REG_MID       = 3'd3;
    localparam logic [2:0] REG_FLOOR     = 3'd4;
    localparam logic [2:0] REG_CEIL      = 3'd5;
    localparam logic [2:0] REG_NULL      = 3'd6;

    localparam logic [63:0] RST_HIGH = 64'h8000_8000_8000_8000;
    localparam logic [63:0] RST_MID  = 64'h4000_4000_4000_4000;

    // Per-item configuration seen by the front end.
    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] mid;
        logic [63:0] flo;
        logic [63:0] cei;
        logic [63:0] nul;
    } t_cfg;

    // Item leaving the front end.
    typedef struct packed {
        logic        vld;
        logic [1:0]  band;
        logic        use_div;
        logic [15:0] y;
        logic [15:0] mul;
        logic [15:0] n;
        logic [15:0] d;
    } t_cls;

    // Item inside the divider.
    typedef struct packed {
        logic        vld;
        logic [1:0]  band;
        logic        use_div;
        logic [15:0] y;
        logic [15:0] rem;
        logic [15:0] lo;
        logic [15:0] q;
        logic [15:0] d;
    } t_div;
endpackage

// ----- hw/rtl/bcs_front.sv -----
// Front end: lane select, mode decode and range classification (two stages).
module bcs_front #(
    parameter int BANDS         = bcs_pkg::DEF_BANDS,
    parameter int FRAC_BITS     = bcs_pkg::DEF_FRAC_BITS,
    parameter int NORM_MIN_CODE = bcs_pkg::DEF_NORM_MIN_CODE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [1:0]          i_band,
    input  logic [15:0]         i_x,
    input  logic                i_partial,
    input  logic                i_pnull,
    input  bcs_pkg::t_cfg       i_cfg,
    output bcs_pkg::t_cls       o_item
);
    localparam logic [15:0] ONE     = 16'(1 << FRAC_BITS);
    localparam logic [15:0] MIN_OUT = 16'(NORM_MIN_CODE);

    typedef struct packed {
        logic        lo;
        logic        hi;
        logic [15:0] n;
        logic [15:0] d;
    } t_rng;

    function automatic t_rng classify(input logic signed [17:0] num_i,
                                      input logic signed [17:0] den_i);
        t_rng r;
        logic signed [17:0] num;
        logic signed [17:0] den;
        num = num_i;
        den = den_i;
        r = '0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (den == 18'sd0) begin
            r.hi = (num > 0);
            r.lo = (num < 0);
        end else if (num < 0) begin
            r.lo = 1'b1;
        end else if (num > den) begin
            r.hi = 1'b1;
        end else begin
            r.n = num[15:0];
            r.d = den[15:0];
        end
        return r;
    endfunction

    // stage A registers
    logic        r_a_vld;
    logic [1:0]  r_a_band;
    logic        r_a_inb;
    logic [2:0]  r_a_mode;
    logic [15:0] r_a_x, r_a_mn, r_a_mx, r_a_med, r_a_flo, r_a_cei, r_a_nul;
    logic        r_a_partial, r_a_pnull;

    logic [5:0] sh;
    assign sh = {i_band, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_band    <= i_band;
            r_a_inb     <= (32'(i_band) < BANDS);
            r_a_mode    <= i_cfg.mode;
            r_a_x       <= i_x;
            r_a_mn      <= i_cfg.low[sh +: 16];
            r_a_mx      <= i_cfg.high[sh +: 16];
            r_a_med     <= i_cfg.mid[sh +: 16];
            r_a_flo     <= i_cfg.flo[sh +: 16];
            r_a_cei     <= i_cfg.cei[sh +: 16];
            r_a_nul     <= i_cfg.nul[sh +: 16];
            r_a_partial <= i_partial;
            r_a_pnull   <= i_pnull;
        end
    end

    bcs_pkg::t_cls n_b;
    bcs_pkg::t_cls r_b;
    t_rng rng;
    logic skip;
    logic signed [17:0] sx, smn, smx, smed;

    always_comb begin
        sx   = $signed({2'b00, r_a_x});
        smn  = $signed({2'b00, r_a_mn});
        smx  = $signed({2'b00, r_a_mx});
        smed = $signed({2'b00, r_a_med});
        skip = r_a_partial && r_a_pnull;
        rng  = '0;
        n_b  = '0;
        n_b.vld  = r_a_vld;
        n_b.band = r_a_band;
        n_b.y    = r_a_x;
        if (r_a_inb) begin
            unique case (r_a_mode)
                bcs_pkg::MODE_CLIP: begin
                    if (r_a_x < r_a_mn || r_a_x > r_a_mx) n_b.y = r_a_nul;
                end
                bcs_pkg::MODE_CLAMP: begin
                    if (!(r_a_partial && r_a_x == r_a_nul)) begin
                        if (r_a_x < r_a_mn) n_b.y = r_a_mn;
                        else if (r_a_x > r_a_mx) n_b.y = r_a_mx;
                    end
                end
                bcs_pkg::MODE_LINEAR: begin
                    if (!skip) begin
                        rng = classify(sx - smn, smx - smn);
                        if (rng.lo) n_b.y = r_a_flo;
                        else if (rng.hi) n_b.y = r_a_cei;
                        else if (rng.d == '0) n_b.y = '0;
                        else begin
                            n_b.use_div = 1'b1;
                            n_b.mul = ONE;
                            n_b.n = rng.n;
                            n_b.d = rng.d;
                        end
                    end
                end
                bcs_pkg::MODE_MEDIAN: begin
                    if (!skip) begin
                        if (r_a_med > r_a_x) begin
                            // left half: divisor is the magnitude of med - min
                            rng = classify(sx - smn, (smed >= smn) ? smed - smn : smn - smed);
                            if (rng.lo) n_b.y = MIN_OUT;
                            else if (rng.hi) n_b.y = r_a_med;
                            else if (rng.d == '0) n_b.y = '0;
                            else begin
                                n_b.use_div = 1'b1;
                                n_b.mul = r_a_med;
                                n_b.n = rng.n;
                                n_b.d = rng.d;
                            end
                        end else begin
                            rng = classify(sx - smed, smx - smed);
                            if (rng.lo) n_b.y = r_a_med;
                            else if (rng.hi) n_b.y = 16'(bcs_pkg::DEF_NORM_MAX_CODE);
                            else n_b.y = r_a_med + rng.n;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else if (i_en) begin
            r_b.vld <= n_b.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b.band    <= n_b.band;
            r_b.use_div <= n_b.use_div;
            r_b.y       <= n_b.y;
            r_b.mul     <= n_b.mul;
            r_b.n       <= n_b.n;
            r_b.d       <= n_b.d;
        end
    end

    assign o_item = r_b;
endmodule

// ----- hw/rtl/bcs_divider.sv -----
// Divider: rounding multiply followed by a radix-2 restoring division pipeline, two quotient bits per stage.
`include "band_clip_and_stretch_macros.svh"
module bcs_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  bcs_pkg::t_cls  i_item,
    output bcs_pkg::t_div  o_item
);
    bcs_pkg::t_div r_dv [0:bcs_pkg::DIV_STAGES];
    bcs_pkg::t_div n_dv [1:bcs_pkg::DIV_STAGES];
    logic [31:0] prod;

    // mul*n + d/2 stays below d << 16, so the quotient fits 16 bits
    assign prod = 32'(i_item.mul) * 32'(i_item.n) + 32'(i_item.d[15:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (i_en) begin
            r_dv[0].vld <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0].band    <= i_item.band;
            r_dv[0].use_div <= i_item.use_div;
            r_dv[0].y       <= i_item.y;
            r_dv[0].rem     <= prod[31:16];
            r_dv[0].lo      <= prod[15:0];
            r_dv[0].q       <= '0;
            r_dv[0].d       <= i_item.d;
        end
    end

    always_comb begin
        logic [16:0] t;
        for (int s = 1; s <= bcs_pkg::DIV_STAGES; s++) begin
            n_dv[s] = r_dv[s-1];
            for (int k = 0; k < bcs_pkg::DIV_BITS; k++) begin
                t = {n_dv[s].rem, n_dv[s].lo[15]};
                n_dv[s].lo = {n_dv[s].lo[14:0], 1'b0};
                if (t >= {1'b0, n_dv[s].d}) begin
                    n_dv[s].rem = 16'(t - {1'b0, n_dv[s].d});
                    n_dv[s].q = {n_dv[s].q[14:0], 1'b1};
                end else begin
                    n_dv[s].rem = t[15:0];
                    n_dv[s].q = {n_dv[s].q[14:0], 1'b0};
                end
            end
        end
    end

    for (genvar g = 1; g <= bcs_pkg::DIV_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g].vld <= 1'b0;
            end else if (i_en) begin
                r_dv[g].vld <= n_dv[g].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g].band    <= n_dv[g].band;
                r_dv[g].use_div <= n_dv[g].use_div;
                r_dv[g].y       <= n_dv[g].y;
                r_dv[g].rem     <= n_dv[g].rem;
                r_dv[g].lo      <= n_dv[g].lo;
                r_dv[g].q       <= n_dv[g].q;
                r_dv[g].d       <= n_dv[g].d;
            end
        end
    end

    assign o_item = r_dv[bcs_pkg::DIV_STAGES];

    `BCS_ASSERT(a_rem_below_div, i_clk, i_rst_n, o_item.vld && o_item.use_div |-> o_item.rem < o_item.d)
    `BCS_ASSERT(a_div_nonzero, i_clk, i_rst_n, o_item.vld && o_item.use_div |-> o_item.d != '0)
    `BCS_ASSERT(a_hold_on_stall, i_clk, i_rst_n, !i_en && o_item.vld |=> $stable(o_item.q) && o_item.vld)
endmodule

// ----- hw/rtl/band_clip_and_stretch.sv -----
// Registered path: front stages A and B, divider stages, output register.
// One sample per cycle unless stalled; the 2-bit-per-stage divider is fully pipelined.
// A stall at the output holds every stage in place; nothing is dropped.
// Reset (synchronous, active low) clears all valid bits and restores register defaults.
// Configuration writes take effect on the next accepted sample.
`include "band_clip_and_stretch_macros.svh"
module band_clip_and_stretch #(
    parameter int BANDS         = bcs_pkg::DEF_BANDS,
    parameter int FRAC_BITS     = bcs_pkg::DEF_FRAC_BITS,
    parameter int NORM_MIN_CODE = bcs_pkg::DEF_NORM_MIN_CODE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_band_index,
    input  logic [15:0] i_sample_in,
    input  logic        i_tile_partial,
    input  logic        i_pixel_null,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_band_out,
    output logic [15:0] o_sample_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    bcs_pkg::t_cfg r_cfg;
    bcs_pkg::t_cls front_item;
    bcs_pkg::t_div div_item;
    logic        en;
    logic        r_vld;
    logic [1:0]  r_band;
    logic [15:0] r_sample;

    // the whole pipe advances when the output slot is free or drained
    assign en      = !r_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= bcs_pkg::MODE_NONE;
            r_cfg.low  <= '0;
            r_cfg.high <= bcs_pkg::RST_HIGH;
            r_cfg.mid  <= bcs_pkg::RST_MID;
            r_cfg.flo  <= '0;
            r_cfg.cei  <= bcs_pkg::RST_HIGH;
            r_cfg.nul  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcs_pkg::REG_CLIP_MODE: r_cfg.mode <= i_cfg_data[2:0];
                bcs_pkg::REG_LOW:       r_cfg.low  <= i_cfg_data;
                bcs_pkg::REG_HIGH:      r_cfg.high <= i_cfg_data;
                bcs_pkg::REG_MID:       r_cfg.mid  <= i_cfg_data;
                bcs_pkg::REG_FLOOR:     r_cfg.flo  <= i_cfg_data;
                bcs_pkg::REG_CEIL:      r_cfg.cei  <= i_cfg_data;
                bcs_pkg::REG_NULL:      r_cfg.nul  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bcs_front #(
        .BANDS(BANDS),
        .FRAC_BITS(FRAC_BITS),
        .NORM_MIN_CODE(NORM_MIN_CODE)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_vld(i_valid),
        .i_band(i_band_index),
        .i_x(i_sample_in),
        .i_partial(i_tile_partial),
        .i_pnull(i_pixel_null),
        .i_cfg(r_cfg),
        .o_item(front_item)
    );

    bcs_divider u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_item(front_item),
        .o_item(div_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= div_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_band   <= div_item.band;
            r_sample <= div_item.use_div ? div_item.q : div_item.y;
        end
    end

    assign o_valid      = r_vld;
    assign o_band_out   = r_band;
    assign o_sample_out = r_sample;

    `BCS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)
    `BCS_ASSERT(a_stall_only_full, i_clk, i_rst_n, !o_ready |-> o_valid && !i_ready)
    `BCS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_sample_out))
endmodule

// ----- verif/band_clip_and_stretch_tb.sv -----
// Self-checking testbench for the band clip and stretch block.
module band_clip_and_stretch_tb;
    localparam int LATENCY = 12;
    localparam int ONE     = 1 << bcs_pkg::DEF_FRAC_BITS;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_band_index;
    logic [15:0] i_sample_in;
    logic        i_tile_partial;
    logic        i_pixel_null;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_band_out;
    logic [15:0] o_sample_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    band_clip_and_stretch dut (.*);

    typedef struct packed {
        logic [1:0]  band;
        logic [15:0] sample;
        logic        partial;
        logic        pnull;
    } t_pixel;

    typedef struct packed {
        logic [1:0]  band;
        logic [15:0] sample;
    } t_stretched;

    // Directed rows: pixel, mode to set first (or keep), and typed-in answer if known.
    typedef struct {
        t_pixel      px;
        logic        set_mode;
        logic [2:0]  mode;
        logic        known;
        logic [15:0] answer;
    } t_row;

    logic [2:0]  cur_mode;
    logic [63:0] cur_low, cur_high, cur_mid, cur_floor, cur_ceil, cur_null;

    t_stretched pending_q[$];
    int         mismatches;
    bit         burst_on;
    bit         hold_off;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("** band_clip_and_stretch: FAILED **");
        $finish;
    end

    function automatic logic [15:0] lane16(logic [63:0] r, logic [1:0] b);
        return r[16*b +: 16];
    endfunction

    // Sort num/den into below, above or inside [0,1].
    function automatic int span_class(longint num, longint den, output longint n,
                                      output longint d);
        n = 0;
        d = 0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (den == 0) begin
            if (num > 0) return 1;
            if (num < 0) return -1;
            return 0;
        end
        if (num < 0) return -1;
        if (num > den) return 1;
        n = num;
        d = den;
        return 0;
    endfunction

    function automatic longint ratio_round(longint mul, longint n, longint d);
        if (d == 0) return 0;
        return (mul * n + d / 2) / d;
    endfunction

    function automatic t_stretched stretch_pixel(t_pixel px);
        t_stretched r;
        longint x, mn, mx, med, nul, n, d, y, den;
        int c;
        x   = px.sample;
        mn  = lane16(cur_low, px.band);
        mx  = lane16(cur_high, px.band);
        med = lane16(cur_mid, px.band);
        nul = lane16(cur_null, px.band);
        y   = x;
        case (cur_mode)
            bcs_pkg::MODE_CLIP: if (x < mn || x > mx) y = nul;
            bcs_pkg::MODE_CLAMP: begin
                if (!(px.partial && x == nul)) begin
                    if (x < mn) y = mn;
                    else if (x > mx) y = mx;
                end
            end
            bcs_pkg::MODE_LINEAR: begin
                if (!(px.partial && px.pnull)) begin
                    c = span_class(x - mn, mx - mn, n, d);
                    if (c < 0) y = lane16(cur_floor, px.band);
                    else if (c > 0) y = lane16(cur_ceil, px.band);
                    else y = ratio_round(ONE, n, d);
                end
            end
            bcs_pkg::MODE_MEDIAN: begin
                if (!(px.partial && px.pnull)) begin
                    if (med > x) begin
                        den = (med > mn) ? med - mn : mn - med;
                        c = span_class(x - mn, den, n, d);
                        if (c < 0) y = bcs_pkg::DEF_NORM_MIN_CODE;
                        else if (c > 0) y = med;
                        else y = ratio_round(med, n, d);
                    end else begin
                        c = span_class(x - med, mx - med, n, d);
                        if (c < 0) y = med;
                        else if (c > 0) y = bcs_pkg::DEF_NORM_MAX_CODE;
                        else y = med + n;
                    end
                end
            end
            default: ;
        endcase
        r.band   = px.band;
        r.sample = y[15:0];
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bcs_pkg::REG_CLIP_MODE: cur_mode  = val[2:0];
            bcs_pkg::REG_LOW:       cur_low   = val;
            bcs_pkg::REG_HIGH:      cur_high  = val;
            bcs_pkg::REG_MID:       cur_mid   = val;
            bcs_pkg::REG_FLOOR:     cur_floor = val;
            bcs_pkg::REG_CEIL:      cur_ceil  = val;
            default:                cur_null  = val;
        endcase
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offer one pixel, honoring the burst pattern; return after its transfer.
    task automatic send_pixel(t_pixel px, logic known, logic [15:0] answer);
        t_stretched e;
        while (!burst_on) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_band_index   <= px.band;
        i_sample_in    <= px.sample;
        i_tile_partial <= px.partial;
        i_pixel_null   <= px.pnull;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        e = stretch_pixel(px);
        if (known && e.sample !== answer) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row band %0d x %0d: typed %0d, predicted %0d",
                         px.band, px.sample, answer, e.sample);
        end
        pending_q.insert(pending_q.size(), e);
    endtask

    // Bias samples toward the band limits and exact extremes.
    function automatic logic [15:0] pick_sample(logic [1:0] b);
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 32768));
            1: return 16'($urandom);
            2: return lane16(cur_low, b) + 16'($urandom_range(0, 2)) - 16'd1;
            3: return lane16(cur_high, b) + 16'($urandom_range(0, 2)) - 16'd1;
            4: return lane16(cur_mid, b) + 16'($urandom_range(0, 2)) - 16'd1;
            default: return ($urandom_range(0, 1) != 0) ? lane16(cur_null, b) : 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'h8000;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic random_config(logic [2:0] mode);
        logic [63:0] lo, hi, md, fl, ce, nu;
        for (int b = 0; b < 4; b++) begin
            lo[16*b +: 16] = 16'($urandom_range(0, 20000));
            hi[16*b +: 16] = 16'($urandom_range(12000, 32768));
            md[16*b +: 16] = 16'($urandom_range(0, 32768));
            fl[16*b +: 16] = pick_limit();
            ce[16*b +: 16] = pick_limit();
            nu[16*b +: 16] = pick_limit();
        end
        // Inverted or equal limits now and then.
        if ($urandom_range(0, 3) == 0) lo[15:0] = hi[15:0];
        if ($urandom_range(0, 3) == 0) lo[31:16] = hi[31:16] + 16'd500;
        if ($urandom_range(0, 4) == 0) md[47:32] = lo[47:32];
        if ($urandom_range(0, 4) == 0) md[63:48] = hi[63:48];
        write_reg(bcs_pkg::REG_CLIP_MODE, {61'd0, mode});
        write_reg(bcs_pkg::REG_LOW, lo);
        write_reg(bcs_pkg::REG_HIGH, hi);
        write_reg(bcs_pkg::REG_MID, md);
        write_reg(bcs_pkg::REG_FLOOR, fl);
        write_reg(bcs_pkg::REG_CEIL, ce);
        write_reg(bcs_pkg::REG_NULL, nu);
    endtask

    // Sender bursts and gaps.
    initial begin
        burst_on = 1'b1;
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_on = 1'b0;
            repeat ($urandom_range(0, 5)) @(posedge i_clk);
            burst_on = 1'b1;
        end
    end

    // Receiver stall pattern, with one long hold-off after reset.
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) i_ready <= 1'b0;
            else case ($urandom_range(0, 9))
                0, 1, 2: i_ready <= 1'b0;
                default: i_ready <= 1'b1;
            endcase
        end
    end

    initial begin
        hold_off = 1'b0;
        @(posedge i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_stretched e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result band %0d sample %0d", o_band_out, o_sample_out);
            end else begin
                e = pending_q.pop_front();
                if (o_band_out !== e.band || o_sample_out !== e.sample) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected band %0d sample %0d, got band %0d sample %0d",
                                 e.band, e.sample, o_band_out, o_sample_out);
                end
            end
        end
    end

    initial begin
        t_row   rows[$];
        t_row   r;
        t_pixel px;
        logic [2:0] m;

        mismatches     = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_band_index   = '0;
        i_sample_in    = '0;
        i_tile_partial = 1'b0;
        i_pixel_null   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = bcs_pkg::REG_CLIP_MODE;
        i_cfg_data     = '0;
        cur_mode  = bcs_pkg::MODE_NONE;
        cur_low   = '0;
        cur_high  = bcs_pkg::RST_HIGH;
        cur_mid   = bcs_pkg::RST_MID;
        cur_floor = '0;
        cur_ceil  = bcs_pkg::RST_HIGH;
        cur_null  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // px, set_mode, mode, known, answer
        rows = '{
            '{'{2'd0, 16'd0,     1'b0, 1'b0}, 1'b0, bcs_pkg::MODE_NONE,   1'b1, 16'd0},
            '{'{2'd3, 16'hFFFF,  1'b1, 1'b1}, 1'b0, bcs_pkg::MODE_NONE,   1'b1, 16'hFFFF},
            '{'{2'd1, 16'd32768, 1'b0, 1'b0}, 1'b1, bcs_pkg::MODE_CLIP,   1'b1, 16'd32768},
            '{'{2'd2, 16'd32769, 1'b0, 1'b0}, 1'b0, bcs_pkg::MODE_CLIP,   1'b1, 16'd0},
            '{'{2'd0, 16'hFFFF,  1'b1, 1'b1}, 1'b1, bcs_pkg::MODE_CLAMP,  1'b1, 16'd32768},
            '{'{2'd1, 16'd0,     1'b1, 1'b0}, 1'b0, bcs_pkg::MODE_CLAMP,  1'b1, 16'd0},
            '{'{2'd2, 16'd0,     1'b0, 1'b0}, 1'b1, bcs_pkg::MODE_LINEAR, 1'b1, 16'd0},
            '{'{2'd3, 16'd32768, 1'b0, 1'b0}, 1'b0, bcs_pkg::MODE_LINEAR, 1'b1, 16'd32768},
            '{'{2'd0, 16'd40000, 1'b0, 1'b1}, 1'b0, bcs_pkg::MODE_LINEAR, 1'b1, 16'd32768},
            '{'{2'd1, 16'd40000, 1'b1, 1'b1}, 1'b0, bcs_pkg::MODE_LINEAR, 1'b1, 16'd40000},
            '{'{2'd2, 16'd12345, 1'b1, 1'b0}, 1'b0, bcs_pkg::MODE_LINEAR, 1'b0, 16'd0},
            '{'{2'd3, 16'd0,     1'b0, 1'b0}, 1'b1, bcs_pkg::MODE_MEDIAN, 1'b0, 16'd0},
            '{'{2'd0, 16'd16384, 1'b0, 1'b0}, 1'b0, bcs_pkg::MODE_MEDIAN, 1'b1, 16'd16384},
            '{'{2'd1, 16'd32768, 1'b0, 1'b0}, 1'b0, bcs_pkg::MODE_MEDIAN, 1'b1, 16'd32768},
            '{'{2'd2, 16'hFFFF,  1'b0, 1'b1}, 1'b0, bcs_pkg::MODE_MEDIAN, 1'b1, 16'd32768},
            '{'{2'd3, 16'd777,   1'b1, 1'b1}, 1'b0, bcs_pkg::MODE_MEDIAN, 1'b1, 16'd777},
            '{'{2'd0, 16'd8191,  1'b0, 1'b0}, 1'b0, bcs_pkg::MODE_MEDIAN, 1'b0, 16'd0},
            '{'{2'd1, 16'd5,     1'b0, 1'b0}, 1'b1, 3'd5,                 1'b1, 16'd5},
            '{'{2'd2, 16'hABCD,  1'b0, 1'b0}, 1'b1, 3'd7,                 1'b1, 16'hABCD}
        };
        foreach (rows[i]) begin
            r = rows[i];
            if (r.set_mode) begin
                drain();
                write_reg(bcs_pkg::REG_CLIP_MODE, {61'd0, r.mode});
            end
            send_pixel(r.px, r.known, r.answer);
        end

        // Degenerate limits: zero divisors in both stretch modes.
        drain();
        write_reg(bcs_pkg::REG_LOW, 64'h0000_FFFF_4000_4000);
        write_reg(bcs_pkg::REG_HIGH, 64'h0000_0000_4000_4000);
        write_reg(bcs_pkg::REG_MID, 64'hFFFF_0000_4000_4000);
        write_reg(bcs_pkg::REG_CLIP_MODE, {61'd0, bcs_pkg::MODE_MEDIAN});
        for (int k = 0; k < 24; k++) begin
            px = '{2'(k), (k % 3 == 0) ? 16'h4000 : ((k % 3 == 1) ? 16'h3FFF : 16'h4001),
                   1'b0, 1'b0};
            if (k == 12) begin
                drain();
                write_reg(bcs_pkg::REG_CLIP_MODE, {61'd0, bcs_pkg::MODE_LINEAR});
            end
            send_pixel(px, 1'b0, '0);
        end

        for (int phase = 0; phase < 10; phase++) begin
            drain();
            m = (phase < 8) ? 3'(phase % 5) : 3'($urandom_range(0, 7));
            random_config(m);
            for (int k = 0; k < 55; k++) begin
                px.band    = 2'($urandom);
                px.sample  = pick_sample(px.band);
                px.partial = 1'($urandom);
                px.pnull   = 1'($urandom);
                send_pixel(px, 1'b0, '0);
            end
        end

        // Inverted extreme limits at the end.
        drain();
        write_reg(bcs_pkg::REG_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(bcs_pkg::REG_HIGH, 64'h0000_0000_0000_0000);
        write_reg(bcs_pkg::REG_NULL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(bcs_pkg::REG_FLOOR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(bcs_pkg::REG_CEIL, 64'h0000_0000_0000_0000);
        write_reg(bcs_pkg::REG_CLIP_MODE, {61'd0, bcs_pkg::MODE_CLAMP});
        for (int k = 0; k < 8; k++) begin
            px = '{2'(k), (k[0]) ? 16'hFFFF : 16'h0000, 1'(k >> 1), 1'b1};
            send_pixel(px, 1'b0, '0);
        end

        drain();
        if (mismatches == 0)
            $display("** band_clip_and_stretch: PASSED **");
        else
            $display("** band_clip_and_stretch: FAILED **");
        $finish;
    end
endmodule

// ----- band_clip_and_stretch.f -----
+incdir+hw/rtl
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_front.sv
hw/rtl/bcs_divider.sv
hw/rtl/band_clip_and_stretch.sv
verif/band_clip_and_stretch_tb.sv
